// ===== design/proxy_v2_header_parser_unit_defines.svh =====
// ----------------------------------------------------------------------------
// PROXY v2 header parser assertion macros
// Shared property wrappers for the parser's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PROXY_V2_HEADER_PARSER_UNIT_DEFINES_SVH
`define PROXY_V2_HEADER_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PV2HP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PV2HP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PV2HP_ASSERT_SAME(lbl, ante, cons, msg)
`define PV2HP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/pv2hp_pkg.sv =====
// ----------------------------------------------------------------------------
// PROXY v2 header parser package
// Phase type, role and status codes, TLV types and CRC32C helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pv2hp_pkg;

    typedef enum logic [3:0] {
        PH_SIG,
        PH_VERCMD,
        PH_FAM,
        PH_LEN,
        PH_ADDR,
        PH_TLVHDR,
        PH_TLVVAL,
        PH_TAIL,
        PH_AFTER
    } phase_t;

    localparam logic [3:0] ROLE_SIG     = 4'd0;
    localparam logic [3:0] ROLE_VERCMD  = 4'd1;
    localparam logic [3:0] ROLE_FAM     = 4'd2;
    localparam logic [3:0] ROLE_LEN     = 4'd3;
    localparam logic [3:0] ROLE_SRCADDR = 4'd4;
    localparam logic [3:0] ROLE_DSTADDR = 4'd5;
    localparam logic [3:0] ROLE_SRCPORT = 4'd6;
    localparam logic [3:0] ROLE_DSTPORT = 4'd7;
    localparam logic [3:0] ROLE_TLVHDR  = 4'd8;
    localparam logic [3:0] ROLE_TLVVAL  = 4'd9;
    localparam logic [3:0] ROLE_TAIL    = 4'd10;
    localparam logic [3:0] ROLE_AFTER   = 4'd11;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_SIG      = 4'd1;
    localparam logic [3:0] ST_VERSION  = 4'd2;
    localparam logic [3:0] ST_CMD      = 4'd3;
    localparam logic [3:0] ST_FAMILY   = 4'd4;
    localparam logic [3:0] ST_LENGTH   = 4'd5;
    localparam logic [3:0] ST_TLVLEN   = 4'd6;
    localparam logic [3:0] ST_CRC      = 4'd7;
    localparam logic [3:0] ST_UNIQUEID = 4'd8;
    localparam logic [3:0] ST_AWS      = 4'd9;
    localparam logic [3:0] ST_AZURE    = 4'd10;

    localparam logic [7:0] T_ALPN      = 8'h01;
    localparam logic [7:0] T_AUTHORITY = 8'h02;
    localparam logic [7:0] T_CRC       = 8'h03;
    localparam logic [7:0] T_UNIQUE    = 8'h05;
    localparam logic [7:0] T_NETNS     = 8'h30;
    localparam logic [7:0] T_AWS       = 8'hEA;
    localparam logic [7:0] T_AZURE     = 8'hEE;

    localparam logic [1:0] FAM_UNSPEC = 2'd0;
    localparam logic [1:0] FAM_INET   = 2'd1;
    localparam logic [1:0] FAM_INET6  = 2'd2;
    localparam logic [1:0] FAM_UNIX   = 2'd3;

    localparam logic [31:0] CRC_POLY = 32'h82F63B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [7:0]  UNIQUE_MAX = 8'd128;

    // Signature byte at a given offset (offsets 0 to 11).
    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'h0D;
            4'd1:    r = 8'h0A;
            4'd2:    r = 8'h0D;
            4'd3:    r = 8'h0A;
            4'd4:    r = 8'h00;
            4'd5:    r = 8'h0D;
            4'd6:    r = 8'h0A;
            4'd7:    r = 8'h51;
            4'd8:    r = 8'h55;
            4'd9:    r = 8'h49;
            4'd10:   r = 8'h54;
            4'd11:   r = 8'h0A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Address block size for a family.
    function automatic logic [7:0] addr_size(input logic [1:0] fam);
        logic [7:0] r;
        case (fam)
            FAM_INET:  r = 8'd12;
            FAM_INET6: r = 8'd36;
            FAM_UNIX:  r = 8'd216;
            default:   r = 8'd0;
        endcase
        return r;
    endfunction

    // One reflected CRC32C byte step.
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/proxy_v2_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// PROXY v2 header parser
// Byte-serial checker and role tagger for PROXY protocol v2 headers.
// ----------------------------------------------------------------------------
// Usage: packet bytes enter on the slave stream, one byte per word, with
// s_tlast on the last byte of each packet. Every accepted word yields
// exactly one result word on the master stream: the byte's role, its TLV
// type and keep flag, a done flag with the status on the byte where the
// header completes or fails, the total header length, and the decoded
// command, family and transport.
// A result appears in the output register on the clock after its byte is
// accepted. Throughput is one byte per cycle while the receiver keeps up;
// the parse state, the CRC32C step and the checks all settle combinationally
// between the input handshake and the output register.
// When the receiver stalls, the output register holds its word and the
// slave side keeps taking bytes only while that register is free or being
// emptied in the same cycle. Reset clears the parse state to the start of
// a signature and empties the output register; the byte marked by s_tlast
// also returns the parser to that start for the next packet.
// ----------------------------------------------------------------------------
`default_nettype none
`include "proxy_v2_header_parser_unit_defines.svh"

module proxy_v2_header_parser_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte [7:0]
    input  wire logic        s_tlast,   // end_of_packet
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // byte_role [3:0], tlv_type [11:4], tlv_kept [12], header_done [13],
    // status [17:14], header_length [34:18], is_local [35],
    // net_family [37:36], transport [39:38]
    output logic [39:0]      m_tdata
);
    import pv2hp_pkg::*;

    logic [16:0] bpos_reg,  bpos_next;
    logic [15:0] decl_reg,  decl_next;
    logic [15:0] rem_reg,   rem_next;
    logic [2:0]  fidx_reg,  fidx_next;
    logic [7:0]  ttype_reg, ttype_next;
    logic [15:0] tlen_reg,  tlen_next;
    logic [31:0] crc_reg,   crc_next;
    logic [31:0] rcrc_reg,  rcrc_next;
    logic        cpres_reg, cpres_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  fac_reg,   fac_next;   // bit0 local, bits 2:1 family, bit3 datagram
    logic [3:0]  err_reg,   err_next;
    logic        skeep_reg, skeep_next;

    logic        out_valid_reg;
    logic [39:0] out_data_reg, out_data_next;
    logic        s_accept;
    logic        out_ok_done;
    logic        at_start;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        logic [3:0]  role;
        logic [7:0]  ttype;
        logic        kept;
        logic        done;
        logic [3:0]  stat;
        logic [3:0]  err;
        logic [7:0]  fb;
        logic [16:0] hlen;
        logic [16:0] off;
        logic [7:0]  asz;
        logic [15:0] len;
        logic [1:0]  fam;
        logic        boundary;
        logic [7:0]  b;
        logic [1:0]  trans;

        b          = s_tdata;
        role       = ROLE_AFTER;
        ttype      = 8'h00;
        kept       = 1'b0;
        done       = 1'b0;
        stat       = ST_OK;
        err        = ST_OK;
        fb         = b;
        hlen       = 17'd0;
        off        = bpos_reg - 17'd16;
        asz        = addr_size(fac_reg[2:1]);
        len        = tlen_reg | {8'h00, b};
        fam        = FAM_UNSPEC;
        boundary   = 1'b0;
        bpos_next  = bpos_reg;
        decl_next  = decl_reg;
        rem_next   = rem_reg;
        fidx_next  = fidx_reg;
        ttype_next = ttype_reg;
        tlen_next  = tlen_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        cpres_next = cpres_reg;
        phase_next = phase_reg;
        fac_next   = fac_reg;
        err_next   = err_reg;
        skeep_next = skeep_reg;

        if (phase_reg == PH_AFTER)
        begin
            stat = err_reg;
            if (err_reg == ST_OK)
            begin
                hlen = 17'd16 + {1'b0, decl_reg};
            end
        end
        else
        begin
            case (phase_reg)
                PH_SIG:
                begin
                    role = ROLE_SIG;
                    if (b != sig_byte(bpos_reg[3:0]))
                    begin
                        err = ST_SIG;
                    end
                    else if (bpos_reg >= 17'd11)
                    begin
                        phase_next = PH_VERCMD;
                    end
                end
                PH_VERCMD:
                begin
                    role = ROLE_VERCMD;
                    if (b[7:4] != 4'd2)
                    begin
                        err = ST_VERSION;
                    end
                    else if (b[3:0] > 4'd1)
                    begin
                        err = ST_CMD;
                    end
                    else
                    begin
                        fac_next   = {3'b000, (b[3:0] == 4'd0)};
                        phase_next = PH_FAM;
                    end
                end
                PH_FAM:
                begin
                    role = ROLE_FAM;
                    if (b == 8'h00 || fac_reg[0])
                    begin
                        fac_next   = {1'b0, FAM_UNSPEC, fac_reg[0]};
                        phase_next = PH_LEN;
                    end
                    else if (b[7:4] >= 4'd1 && b[7:4] <= 4'd3 &&
                             (b[3:0] == 4'd1 || b[3:0] == 4'd2))
                    begin
                        fac_next   = {(b[3:0] == 4'd2), b[5:4], fac_reg[0]};
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        err = ST_FAMILY;
                    end
                end
                PH_LEN:
                begin
                    role = ROLE_LEN;
                    if (bpos_reg == 17'd14)
                    begin
                        decl_next = {b, 8'h00};
                    end
                    else
                    begin
                        decl_next = decl_reg | {8'h00, b};
                        if (decl_next < {8'h00, asz})
                        begin
                            err = ST_LENGTH;
                        end
                        else
                        begin
                            rem_next = decl_next - {8'h00, asz};
                            if (asz != 8'd0)
                            begin
                                phase_next = PH_ADDR;
                            end
                            else
                            begin
                                boundary = 1'b1;
                            end
                        end
                    end
                end
                PH_ADDR:
                begin
                    case (fac_reg[2:1])
                        FAM_INET:
                        begin
                            role = (off < 17'd4)  ? ROLE_SRCADDR :
                                   (off < 17'd8)  ? ROLE_DSTADDR :
                                   (off < 17'd10) ? ROLE_SRCPORT : ROLE_DSTPORT;
                        end
                        FAM_INET6:
                        begin
                            role = (off < 17'd16) ? ROLE_SRCADDR :
                                   (off < 17'd32) ? ROLE_DSTADDR :
                                   (off < 17'd34) ? ROLE_SRCPORT : ROLE_DSTPORT;
                        end
                        default:
                        begin
                            role = (off < 17'd108) ? ROLE_SRCADDR : ROLE_DSTADDR;
                        end
                    endcase
                    if (off + 17'd1 >= {9'h000, asz})
                    begin
                        boundary = 1'b1;
                    end
                end
                PH_TLVHDR:
                begin
                    role = ROLE_TLVHDR;
                    if (fidx_reg == 3'd0)
                    begin
                        ttype_next = b;
                        skeep_next = 1'b0;
                        fidx_next  = 3'd1;
                    end
                    else if (fidx_reg == 3'd1)
                    begin
                        tlen_next = {b, 8'h00};
                        fidx_next = 3'd2;
                    end
                    else
                    begin
                        if ({1'b0, len} + 17'd1 > {1'b0, rem_reg})
                        begin
                            err = ST_TLVLEN;
                        end
                        else if (ttype_reg == T_CRC && len != 16'd4)
                        begin
                            err = ST_CRC;
                        end
                        else if (ttype_reg == T_UNIQUE && len > {8'h00, UNIQUE_MAX})
                        begin
                            err = ST_UNIQUEID;
                        end
                        else if (ttype_reg == T_AWS && len < 16'd2)
                        begin
                            err = ST_AWS;
                        end
                        else if (ttype_reg == T_AZURE && len < 16'd5)
                        begin
                            err = ST_AZURE;
                        end
                        tlen_next = len;
                        if (ttype_reg == T_CRC)
                        begin
                            cpres_next = 1'b1;
                            rcrc_next  = 32'h0;
                        end
                        fidx_next = 3'd3;
                    end
                    rem_next = rem_reg - 16'd1;
                    if (err == ST_OK && fidx_next == 3'd3)
                    begin
                        if (tlen_next == 16'd0)
                        begin
                            boundary = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_TLVVAL;
                        end
                    end
                end
                PH_TLVVAL:
                begin
                    role = ROLE_TLVVAL;
                    if (ttype_reg == T_CRC)
                    begin
                        rcrc_next = {rcrc_reg[23:0], b};
                        fb        = 8'h00;
                    end
                    if (fidx_reg == 3'd3)
                    begin
                        if (ttype_reg == T_AWS || ttype_reg == T_AZURE)
                        begin
                            skeep_next = (b == 8'h01);
                        end
                        fidx_next = 3'd4;
                    end
                    rem_next  = rem_reg - 16'd1;
                    tlen_next = tlen_reg - 16'd1;
                    if (tlen_next == 16'd0)
                    begin
                        boundary = 1'b1;
                    end
                end
                default:
                begin
                    role     = ROLE_TAIL;
                    rem_next = rem_reg - 16'd1;
                end
            endcase

            // A new TLV needs at least a full three-byte header.
            if (boundary)
            begin
                fidx_next  = 3'd0;
                phase_next = (rem_next >= 16'd3) ? PH_TLVHDR : PH_TAIL;
            end

            if (role == ROLE_TLVHDR || role == ROLE_TLVVAL)
            begin
                ttype = ttype_next;
                if (ttype_next == T_ALPN || ttype_next == T_AUTHORITY ||
                    ttype_next == T_CRC || ttype_next == T_UNIQUE || ttype_next == T_NETNS)
                begin
                    kept = 1'b1;
                end
                else if ((ttype_next == T_AWS || ttype_next == T_AZURE) &&
                         role == ROLE_TLVVAL)
                begin
                    kept = skeep_next;
                end
            end

            crc_next = crc32c_byte(crc_reg, fb);

            if (err == ST_OK && bpos_reg >= 17'd15 &&
                bpos_reg == 17'd15 + {1'b0, decl_next})
            begin
                done = 1'b1;
                if (cpres_next && (crc_next ^ CRC_INIT) != rcrc_next)
                begin
                    stat = ST_CRC;
                end
                err_next   = stat;
                phase_next = PH_AFTER;
                if (stat == ST_OK)
                begin
                    hlen = 17'd16 + {1'b0, decl_next};
                end
            end
            if (err == ST_OK && !done && s_tlast)
            begin
                err = ST_LENGTH;
            end
            if (err != ST_OK)
            begin
                done       = 1'b1;
                stat       = err;
                err_next   = err;
                phase_next = PH_AFTER;
            end
            bpos_next = bpos_reg + 17'd1;
        end

        fam   = fac_next[2:1];
        trans = (fam != FAM_UNSPEC) ? (fac_next[3] ? 2'd2 : 2'd1) : 2'd0;
        out_data_next = {trans, fam, fac_next[0], hlen, stat, done, kept, ttype, role};

        // The last byte of a packet returns the parser to its start.
        if (s_tlast)
        begin
            bpos_next  = 17'd0;
            decl_next  = 16'd0;
            rem_next   = 16'd0;
            fidx_next  = 3'd0;
            ttype_next = 8'h00;
            tlen_next  = 16'd0;
            crc_next   = CRC_INIT;
            rcrc_next  = 32'h0;
            cpres_next = 1'b0;
            phase_next = PH_SIG;
            fac_next   = 4'h0;
            err_next   = ST_OK;
            skeep_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpos_reg  <= 17'd0;
            decl_reg  <= 16'd0;
            rem_reg   <= 16'd0;
            fidx_reg  <= 3'd0;
            ttype_reg <= 8'h00;
            tlen_reg  <= 16'd0;
            crc_reg   <= CRC_INIT;
            rcrc_reg  <= 32'h0;
            cpres_reg <= 1'b0;
            phase_reg <= PH_SIG;
            fac_reg   <= 4'h0;
            err_reg   <= ST_OK;
            skeep_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            bpos_reg  <= bpos_next;
            decl_reg  <= decl_next;
            rem_reg   <= rem_next;
            fidx_reg  <= fidx_next;
            ttype_reg <= ttype_next;
            tlen_reg  <= tlen_next;
            crc_reg   <= crc_next;
            rcrc_reg  <= rcrc_next;
            cpres_reg <= cpres_next;
            phase_reg <= phase_next;
            fac_reg   <= fac_next;
            err_reg   <= err_next;
            skeep_reg <= skeep_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_ok_done = m_tvalid && m_tdata[13] && m_tdata[17:14] == ST_OK;
    assign at_start    = phase_reg == PH_SIG && bpos_reg == 17'd0;

    // A successful header always reports at least its fixed 16 bytes.
    `PV2HP_ASSERT_SAME(a_ok_len, out_ok_done, m_tdata[34:18] >= 17'd16, "short ok length")
    // The signature phase never runs past the twelve signature bytes.
    `PV2HP_ASSERT_SAME(a_sig_pos, phase_reg == PH_SIG, bpos_reg < 17'd12, "signature overrun")
    // The end of a packet restarts parsing at the signature.
    `PV2HP_ASSERT_NEXT(a_eop_restart, s_accept && s_tlast, at_start, "no restart at packet end")

endmodule

`default_nettype wire
